/* rtl/tpeq_pkg.sv */
// ----------------------------------------------------------------------------
// tpeq_pkg
// Shared types and constants of the timed priority event queue.
// ----------------------------------------------------------------------------
package tpeq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // operation codes
    localparam logic [1:0] OP_ADD       = 2'd0;
    localparam logic [1:0] OP_GET       = 2'd1;
    localparam logic [1:0] OP_FLUSH_PND = 2'd2;
    localparam logic [1:0] OP_FLUSH_RDY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PUSH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_KIND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_KIND = 2'd2;

    // one stored event
    typedef struct packed {
        logic [3:0]           ev_kind;
        logic [7:0]           ev_task;
        logic [7:0]           ev_frame;
        logic [7:0]           ev_value;
        logic [TIME_BITS-1:0] ev_trig;
    } t_evt;

    localparam int EVT_W = $bits(t_evt);

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  event_kind;
        logic [7:0]  scr_task;
        logic [7:0]  dest_frame;
        logic [7:0]  event_value;
        logic [31:0] trigger_time;
        logic [31:0] now_time;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        event_valid;
        logic [3:0]  out_kind;
        logic [7:0]  out_task;
        logic [7:0]  out_frame;
        logic [7:0]  out_value;
        logic [31:0] out_trigger;
        logic [15:0] overflow_count;
        logic [5:0]  high_water;
    } t_out;

    // sequencer states
    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_SCAN     = 17'h00002,
        S_SCAN_CHK = 17'h00004,
        S_FULL_CHK = 17'h00008,
        S_INS_RD   = 17'h00010,
        S_INS_CHK  = 17'h00020,
        S_MRG_I    = 17'h00040,
        S_MRG_IW   = 17'h00080,
        S_MRG_J    = 17'h00100,
        S_MRG_JC   = 17'h00200,
        S_CMP_RD   = 17'h00400,
        S_CMP_WR   = 17'h00800,
        S_POP      = 17'h01000,
        S_POP_W    = 17'h02000,
        S_SHF_RD   = 17'h04000,
        S_SHF_WR   = 17'h08000,
        S_DONE     = 17'h10000
    } t_state;

endpackage

/* rtl/tpeq_ram.sv */
// ----------------------------------------------------------------------------
// tpeq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tpeq_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/timed_priority_event_queue.sv */
// ----------------------------------------------------------------------------
// timed_priority_event_queue
// Pending table of timed events feeding a kind-sorted ready list.
// ----------------------------------------------------------------------------
// One item at a time. Add and both flushes go from idle straight to the
// output state. Get next walks all 32 pending slots through the pending RAM
// read port (a waiting slot takes an extra compare state), each released
// event is inserted by walking the ready list RAM from its tail, coalescing
// runs a pair scan over the ready list (up to about n*n/2 reads) when an
// event was released, then compaction and the head pop walk the listed
// entries through the single read port of the ready list RAM.
// Both RAMs hold their contents over reset; pending slots carry valid flops.
module timed_priority_event_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tpeq_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tpeq_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [tpeq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tpeq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    tpeq_pkg::t_state r_state, n_state;

    logic [tpeq_pkg::QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [tpeq_pkg::QUEUE_DEPTH-1:0] r_keep, n_keep;
    logic [tpeq_pkg::CNT_W-1:0]       r_i, n_i, r_j, n_j, r_k, n_k, r_n, n_n;
    logic [tpeq_pkg::CNT_W-1:0]       r_cnt, n_cnt, r_peak, n_peak;
    logic [15:0]                      r_lost, n_lost;
    logic                             r_moved, n_moved;
    logic [tpeq_pkg::TIME_BITS-1:0]   r_now, n_now;
    tpeq_pkg::t_evt                   r_evt, n_evt, r_ei, n_ei;
    tpeq_pkg::t_out                   r_res, n_res, r_out, n_out;
    logic                             r_out_valid, n_out_valid;
    logic                             r_allow;
    logic [3:0]                       r_push_kind, r_screen_kind;

    // RAM ports
    logic                        p_we, l_we;
    logic [tpeq_pkg::IDX_W-1:0]  p_waddr, p_raddr, l_waddr, l_raddr;
    tpeq_pkg::t_evt              p_wdata, p_rdata, l_wdata, l_rdata;

    // free slot search
    logic                        free_hit;
    logic [tpeq_pkg::IDX_W-1:0]  free_idx;
    logic [tpeq_pkg::CNT_W-1:0]  free_next;
    tpeq_pkg::t_evt              in_evt;
    logic                        in_fire, refused, coalesce;

    // previous list positions
    logic [tpeq_pkg::CNT_W-1:0]  k_dec, i_dec;

    tpeq_ram #(.W(tpeq_pkg::EVT_W), .D(tpeq_pkg::QUEUE_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    tpeq_ram #(.W(tpeq_pkg::EVT_W), .D(tpeq_pkg::QUEUE_DEPTH)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign o_in_ready  = (r_state == tpeq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;

    assign in_evt.ev_kind  = i_in_data.event_kind;
    assign in_evt.ev_task  = i_in_data.scr_task;
    assign in_evt.ev_frame = i_in_data.dest_frame;
    assign in_evt.ev_value = i_in_data.event_value;
    assign in_evt.ev_trig  = i_in_data.trigger_time[tpeq_pkg::TIME_BITS-1:0];

    assign refused = (i_in_data.event_kind == 4'd0) ||
                     ((i_in_data.event_kind == r_push_kind) && !r_allow);

    assign k_dec = r_k - tpeq_pkg::CNT_ONE;
    assign i_dec = r_i - tpeq_pkg::CNT_ONE;

    // lowest free pending slot
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int s = tpeq_pkg::QUEUE_DEPTH - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_hit = 1'b1;
                free_idx = s[tpeq_pkg::IDX_W-1:0];
            end
        end
    end
    assign free_next = {1'b0, free_idx} + tpeq_pkg::CNT_ONE;

    // duplicate test of the later entry against the kept one
    assign coalesce = (l_rdata.ev_kind == r_ei.ev_kind) &&
                      ((r_ei.ev_kind == r_push_kind) ||
                       ((r_ei.ev_kind == r_screen_kind) &&
                        (l_rdata.ev_task == r_ei.ev_task) &&
                        (l_rdata.ev_frame == r_ei.ev_frame)));

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_keep      = r_keep;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_peak      = r_peak;
        n_lost      = r_lost;
        n_moved     = r_moved;
        n_now       = r_now;
        n_evt       = r_evt;
        n_ei        = r_ei;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        p_we        = 1'b0;
        p_waddr     = free_idx;
        p_wdata     = in_evt;
        p_raddr     = r_i[tpeq_pkg::IDX_W-1:0];
        l_we        = 1'b0;
        l_waddr     = r_k[tpeq_pkg::IDX_W-1:0];
        l_wdata     = r_evt;
        l_raddr     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tpeq_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_res   = '0;
                    n_state = tpeq_pkg::S_DONE;
                    case (i_in_data.operation)
                        tpeq_pkg::OP_ADD: begin
                            if (!refused) begin
                                if (free_hit) begin
                                    p_we               = 1'b1;
                                    n_valid[free_idx]  = 1'b1;
                                    n_res.accepted     = 1'b1;
                                    if (free_next > r_peak) begin
                                        n_peak = free_next;
                                    end
                                end else begin
                                    n_lost = r_lost + 16'd1;
                                end
                            end
                        end
                        tpeq_pkg::OP_GET: begin
                            n_now   = i_in_data.now_time[tpeq_pkg::TIME_BITS-1:0];
                            n_i     = '0;
                            n_moved = 1'b0;
                            n_state = tpeq_pkg::S_SCAN;
                        end
                        tpeq_pkg::OP_FLUSH_PND: n_valid = '0;
                        default:                n_cnt   = '0;
                    endcase
                end
            end

            // walk pending slots in order
            tpeq_pkg::S_SCAN: begin
                if (r_i == tpeq_pkg::CNT_FULL) begin
                    if (r_cnt == '0) begin
                        n_state = tpeq_pkg::S_DONE;
                    end else if (r_moved) begin
                        n_keep  = '1;
                        n_i     = '0;
                        n_state = tpeq_pkg::S_MRG_I;
                    end else begin
                        n_state = tpeq_pkg::S_POP;
                    end
                end else if (r_valid[r_i[tpeq_pkg::IDX_W-1:0]]) begin
                    n_state = tpeq_pkg::S_SCAN_CHK;
                end else begin
                    n_i = r_i + tpeq_pkg::CNT_ONE;
                end
            end
            tpeq_pkg::S_SCAN_CHK: begin
                n_evt = p_rdata;
                if (r_now >= p_rdata.ev_trig) begin
                    if (r_cnt == tpeq_pkg::CNT_FULL) begin
                        l_raddr = '1;
                        n_state = tpeq_pkg::S_FULL_CHK;
                    end else begin
                        n_k     = r_cnt;
                        n_state = tpeq_pkg::S_INS_RD;
                    end
                end else begin
                    n_i     = r_i + tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_SCAN;
                end
            end
            // full list: enter only above the tail, which is dropped
            tpeq_pkg::S_FULL_CHK: begin
                if (l_rdata.ev_kind < r_evt.ev_kind) begin
                    n_k     = tpeq_pkg::CNT_FULL - tpeq_pkg::CNT_ONE;
                    n_cnt   = r_cnt - tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_INS_RD;
                end else begin
                    n_i     = r_i + tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_SCAN;
                end
            end
            // insertion walk from the tail toward the head
            tpeq_pkg::S_INS_RD: begin
                if (r_k == '0) begin
                    l_we                                  = 1'b1;
                    n_valid[r_i[tpeq_pkg::IDX_W-1:0]]     = 1'b0;
                    n_moved                               = 1'b1;
                    n_cnt                                 = r_cnt + tpeq_pkg::CNT_ONE;
                    n_i                                   = r_i + tpeq_pkg::CNT_ONE;
                    n_state                               = tpeq_pkg::S_SCAN;
                end else begin
                    l_raddr = k_dec[tpeq_pkg::IDX_W-1:0];
                    n_state = tpeq_pkg::S_INS_CHK;
                end
            end
            tpeq_pkg::S_INS_CHK: begin
                l_we = 1'b1;
                if (l_rdata.ev_kind < r_evt.ev_kind) begin
                    l_wdata = l_rdata;
                    n_k     = r_k - tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_INS_RD;
                end else begin
                    n_valid[r_i[tpeq_pkg::IDX_W-1:0]] = 1'b0;
                    n_moved = 1'b1;
                    n_cnt   = r_cnt + tpeq_pkg::CNT_ONE;
                    n_i     = r_i + tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_SCAN;
                end
            end

            // coalescing pair scan
            tpeq_pkg::S_MRG_I: begin
                l_raddr = r_i[tpeq_pkg::IDX_W-1:0];
                if (r_i == r_cnt) begin
                    n_i     = '0;
                    n_n     = '0;
                    n_state = tpeq_pkg::S_CMP_RD;
                end else if (r_keep[r_i[tpeq_pkg::IDX_W-1:0]]) begin
                    n_state = tpeq_pkg::S_MRG_IW;
                end else begin
                    n_i = r_i + tpeq_pkg::CNT_ONE;
                end
            end
            tpeq_pkg::S_MRG_IW: begin
                n_ei    = l_rdata;
                n_j     = r_i + tpeq_pkg::CNT_ONE;
                n_state = tpeq_pkg::S_MRG_J;
            end
            tpeq_pkg::S_MRG_J: begin
                l_raddr = r_j[tpeq_pkg::IDX_W-1:0];
                if (r_j == r_cnt) begin
                    n_i     = r_i + tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_MRG_I;
                end else if (r_keep[r_j[tpeq_pkg::IDX_W-1:0]]) begin
                    n_state = tpeq_pkg::S_MRG_JC;
                end else begin
                    n_j = r_j + tpeq_pkg::CNT_ONE;
                end
            end
            tpeq_pkg::S_MRG_JC: begin
                if (coalesce) begin
                    n_keep[r_j[tpeq_pkg::IDX_W-1:0]] = 1'b0;
                end
                n_j     = r_j + tpeq_pkg::CNT_ONE;
                n_state = tpeq_pkg::S_MRG_J;
            end

            // compaction of kept entries
            tpeq_pkg::S_CMP_RD: begin
                l_raddr = r_i[tpeq_pkg::IDX_W-1:0];
                if (r_i == r_cnt) begin
                    n_cnt   = r_n;
                    n_state = tpeq_pkg::S_POP;
                end else if (r_keep[r_i[tpeq_pkg::IDX_W-1:0]]) begin
                    n_state = tpeq_pkg::S_CMP_WR;
                end else begin
                    n_i = r_i + tpeq_pkg::CNT_ONE;
                end
            end
            tpeq_pkg::S_CMP_WR: begin
                l_we    = 1'b1;
                l_waddr = r_n[tpeq_pkg::IDX_W-1:0];
                l_wdata = l_rdata;
                n_n     = r_n + tpeq_pkg::CNT_ONE;
                n_i     = r_i + tpeq_pkg::CNT_ONE;
                n_state = tpeq_pkg::S_CMP_RD;
            end

            // head pop and shift
            tpeq_pkg::S_POP: begin
                l_raddr = '0;
                n_state = tpeq_pkg::S_POP_W;
            end
            tpeq_pkg::S_POP_W: begin
                n_res.event_valid = 1'b1;
                n_res.out_kind    = l_rdata.ev_kind;
                n_res.out_task    = l_rdata.ev_task;
                n_res.out_frame   = l_rdata.ev_frame;
                n_res.out_value   = l_rdata.ev_value;
                n_res.out_trigger = l_rdata.ev_trig;
                n_i               = tpeq_pkg::CNT_ONE;
                n_state           = tpeq_pkg::S_SHF_RD;
            end
            tpeq_pkg::S_SHF_RD: begin
                l_raddr = r_i[tpeq_pkg::IDX_W-1:0];
                if (r_i == r_cnt) begin
                    n_cnt   = r_cnt - tpeq_pkg::CNT_ONE;
                    n_state = tpeq_pkg::S_DONE;
                end else begin
                    n_state = tpeq_pkg::S_SHF_WR;
                end
            end
            tpeq_pkg::S_SHF_WR: begin
                l_we    = 1'b1;
                l_waddr = i_dec[tpeq_pkg::IDX_W-1:0];
                l_wdata = l_rdata;
                n_i     = r_i + tpeq_pkg::CNT_ONE;
                n_state = tpeq_pkg::S_SHF_RD;
            end

            // hand the item to the output register
            tpeq_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out                = r_res;
                    n_out.overflow_count = r_lost;
                    n_out.high_water     = r_peak;
                    n_out_valid          = 1'b1;
                    n_state              = tpeq_pkg::S_IDLE;
                end
            end
            default: n_state = tpeq_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpeq_pkg::S_IDLE;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_peak      <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_peak      <= n_peak;
            r_lost      <= n_lost;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_keep  <= n_keep;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_n     <= n_n;
        r_moved <= n_moved;
        r_now   <= n_now;
        r_evt   <= n_evt;
        r_ei    <= n_ei;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow       <= 1'b0;
            r_push_kind   <= 4'd1;
            r_screen_kind <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpeq_pkg::CFG_ALLOW_PUSH:  r_allow       <= i_cfg_data[0];
                tpeq_pkg::CFG_PUSH_KIND:   r_push_kind   <= i_cfg_data;
                tpeq_pkg::CFG_SCREEN_KIND: r_screen_kind <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/tpeq_checker.sv */
// ----------------------------------------------------------------------------
// tpeq_checker
// Port-level checks of the timed priority event queue, bound to the top level.
// ----------------------------------------------------------------------------
module tpeq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tpeq_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // an add result never carries a popped event
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.accepted && o_out_data.event_valid))
        else $error("accepted and event_valid both set");

    // empty pop reports zero, a real pop a nonzero kind
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_valid == (o_out_data.out_kind != 4'd0)))
        else $error("pop kind inconsistent with event_valid");

    // high water mark stays within the table
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.high_water <= 6'(tpeq_pkg::QUEUE_DEPTH))
        else $error("high water beyond table depth");

endmodule

bind timed_priority_event_queue tpeq_checker u_tpeq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
